@@ design/m3i_pkg.sv @@
// Package for the 3x3 matrix inverse: item types, widths and constants.
// No dependencies; used by every design file.
package m3i_pkg;

    localparam int ELEM_W = 32;
    localparam int THR_W  = 31;
    localparam int ADJ_W  = 64;
    localparam int MAG_W  = 97;
    localparam int QBITS  = 31;
    localparam int LATENCY = 40;

    localparam logic [THR_W-1:0]  THR_RESET = 31'd33;
    localparam logic [ELEM_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG   = 32'h8000_0000;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_elem0;
        logic signed [ELEM_W-1:0] a_elem1;
        logic signed [ELEM_W-1:0] a_elem2;
        logic signed [ELEM_W-1:0] a_elem3;
        logic signed [ELEM_W-1:0] a_elem4;
        logic signed [ELEM_W-1:0] a_elem5;
        logic signed [ELEM_W-1:0] a_elem6;
        logic signed [ELEM_W-1:0] a_elem7;
        logic signed [ELEM_W-1:0] a_elem8;
    } in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_elem0;
        logic signed [ELEM_W-1:0] inv_elem1;
        logic signed [ELEM_W-1:0] inv_elem2;
        logic signed [ELEM_W-1:0] inv_elem3;
        logic signed [ELEM_W-1:0] inv_elem4;
        logic signed [ELEM_W-1:0] inv_elem5;
        logic signed [ELEM_W-1:0] inv_elem6;
        logic signed [ELEM_W-1:0] inv_elem7;
        logic signed [ELEM_W-1:0] inv_elem8;
        logic                     singular;
    } out_t;

    typedef struct packed {
        logic big;
        logic neg;
    } lane_ctl_t;

endpackage

@@ design/m3i_div_lane.sv @@
// One pipelined restoring divider lane: (|adj| << 32) / |det|, one quotient bit a stage.
// Depends on m3i_pkg. Registered as 31 bit stages and a result register.
module m3i_div_lane (
    input  logic                              clk,
    input  logic [m3i_pkg::MAG_W-1:0]         mag,
    input  logic [m3i_pkg::MAG_W-1:0]         rem0,
    input  m3i_pkg::lane_ctl_t                ctl,
    output logic [m3i_pkg::ELEM_W-1:0]        res
);

    localparam int N = m3i_pkg::QBITS;

    logic [m3i_pkg::MAG_W-1:0]  rem_reg [1:N];
    logic [m3i_pkg::MAG_W-1:0]  mag_reg [1:N];
    logic [N-1:0]               q_reg   [1:N];
    m3i_pkg::lane_ctl_t         ctl_reg [1:N];
    logic [m3i_pkg::ELEM_W-1:0] res_reg;
    logic [m3i_pkg::ELEM_W-1:0] res_next;

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [m3i_pkg::MAG_W-1:0] rem_in;
        logic [m3i_pkg::MAG_W-1:0] mag_in;
        logic [N-1:0]              q_in;
        m3i_pkg::lane_ctl_t        ctl_in;
        logic [m3i_pkg::MAG_W:0]   t;
        logic                      ge;
        if (s == 0)
        begin : g_head
            assign rem_in = rem0;
            assign mag_in = mag;
            assign q_in   = '0;
            assign ctl_in = ctl;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[s];
            assign mag_in = mag_reg[s];
            assign q_in   = q_reg[s];
            assign ctl_in = ctl_reg[s];
        end
        assign t  = {rem_in, 1'b0};
        assign ge = t >= {1'b0, mag_in};
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? m3i_pkg::MAG_W'(t - {1'b0, mag_in})
                               : m3i_pkg::MAG_W'(t);
            mag_reg[s+1] <= mag_in;
            q_reg[s+1]   <= {q_in[N-2:0], ge};
            ctl_reg[s+1] <= ctl_in;
        end
    end

    always_comb
    begin
        if (ctl_reg[N].big)
            res_next = ctl_reg[N].neg ? m3i_pkg::SAT_NEG : m3i_pkg::SAT_POS;
        else if (ctl_reg[N].neg)
            res_next = m3i_pkg::ELEM_W'(0) - {1'b0, q_reg[N]};
        else
            res_next = {1'b0, q_reg[N]};
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

@@ design/matrix3_inverse.sv @@
// Top level of the 3x3 Q16.16 matrix inverse: cofactors, determinant, nine divider lanes.
// Depends on m3i_pkg and m3i_div_lane.
// Takes one matrix per cycle; busy is never raised. Each result passes through 7 stages of
// multiply and add, then the divider lanes' 31 bit stages and result register. The receiver
// cannot stall: done is high for one cycle with the result. A singular matrix yields identity.
module matrix3_inverse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  m3i_pkg::in_t                  a,
    input  logic                          thr_we,
    input  logic [m3i_pkg::THR_W-1:0]     thr_wdata,
    output logic                          done,
    output m3i_pkg::out_t                 result
);

    localparam int VLEN = 39;
    localparam int SLEN = 33;

    logic [m3i_pkg::THR_W-1:0] thr_reg;
    logic [VLEN-1:0]           v_reg;
    logic                      done_reg;

    logic signed [31:0]  m_reg    [0:8];
    logic signed [31:0]  m1_reg   [0:2];
    logic signed [31:0]  m2_reg   [0:2];
    logic signed [63:0]  p_reg    [0:17];
    logic signed [63:0]  adj2_reg [0:8];
    logic signed [63:0]  adj3_reg [0:8];
    logic signed [63:0]  adj4_reg [0:8];
    logic signed [63:0]  adj5_reg [0:8];
    logic signed [63:0]  hp_reg   [0:2];
    logic signed [64:0]  lp_reg   [0:2];
    logic signed [98:0]  term_reg [0:2];
    logic signed [98:0]  det_reg;
    logic [96:0]         mag_reg;
    logic [96:0]         rem_reg  [0:8];
    m3i_pkg::lane_ctl_t  ctl_reg  [0:8];
    logic                sing_reg [0:SLEN-1];
    logic [31:0]         lane_res [0:8];
    m3i_pkg::out_t       out_reg;
    m3i_pkg::out_t       out_next;

    logic signed [63:0]  adj_next [0:8];
    logic [98:0]         mag_full;
    logic                dneg;
    logic                sing_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= m3i_pkg::THR_RESET;
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (thr_we)
                thr_reg <= thr_wdata;
            v_reg    <= {v_reg[VLEN-2:0], start};
            done_reg <= v_reg[VLEN-1];
        end
    end

    // stage 0..1: capture and the eighteen 2x2 minor products
    always_ff @(posedge clk)
    begin
        m_reg[0] <= a.a_elem0;
        m_reg[1] <= a.a_elem1;
        m_reg[2] <= a.a_elem2;
        m_reg[3] <= a.a_elem3;
        m_reg[4] <= a.a_elem4;
        m_reg[5] <= a.a_elem5;
        m_reg[6] <= a.a_elem6;
        m_reg[7] <= a.a_elem7;
        m_reg[8] <= a.a_elem8;
        p_reg[0]  <= m_reg[4] * m_reg[8];
        p_reg[1]  <= m_reg[5] * m_reg[7];
        p_reg[2]  <= m_reg[7] * m_reg[2];
        p_reg[3]  <= m_reg[1] * m_reg[8];
        p_reg[4]  <= m_reg[1] * m_reg[5];
        p_reg[5]  <= m_reg[4] * m_reg[2];
        p_reg[6]  <= m_reg[5] * m_reg[6];
        p_reg[7]  <= m_reg[3] * m_reg[8];
        p_reg[8]  <= m_reg[0] * m_reg[8];
        p_reg[9]  <= m_reg[6] * m_reg[2];
        p_reg[10] <= m_reg[3] * m_reg[2];
        p_reg[11] <= m_reg[0] * m_reg[5];
        p_reg[12] <= m_reg[3] * m_reg[7];
        p_reg[13] <= m_reg[6] * m_reg[4];
        p_reg[14] <= m_reg[6] * m_reg[1];
        p_reg[15] <= m_reg[0] * m_reg[7];
        p_reg[16] <= m_reg[0] * m_reg[4];
        p_reg[17] <= m_reg[1] * m_reg[3];
        for (int i = 0; i < 3; i++)
        begin
            m1_reg[i] <= m_reg[i];
            m2_reg[i] <= m1_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            adj_next[i] = p_reg[2*i] - p_reg[2*i+1];
    end

    // stages 2..5: cofactors, split products, terms, determinant
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            adj2_reg[i] <= adj_next[i];
            adj3_reg[i] <= adj2_reg[i];
            adj4_reg[i] <= adj3_reg[i];
            adj5_reg[i] <= adj4_reg[i];
        end
        for (int k = 0; k < 3; k++)
        begin
            hp_reg[k]   <= m2_reg[k] * $signed(adj2_reg[3*k][63:32]);
            lp_reg[k]   <= m2_reg[k] * $signed({1'b0, adj2_reg[3*k][31:0]});
            term_reg[k] <= $signed({{3{hp_reg[k][63]}}, hp_reg[k], 32'b0})
                         + $signed({{34{lp_reg[k][64]}}, lp_reg[k]});
        end
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
    end

    // stage 6: magnitude, singular test, lane set-up
    assign dneg      = det_reg[98];
    assign mag_full  = dneg ? 99'(-det_reg) : 99'(det_reg);
    assign sing_next = (mag_full == '0) || (mag_full < {36'b0, thr_reg, 32'b0});

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_full[96:0];
        sing_reg[0] <= sing_next;
        for (int i = 1; i < SLEN; i++)
            sing_reg[i] <= sing_reg[i-1];
        for (int i = 0; i < 9; i++)
        begin
            logic [63:0] ua;
            ua = adj5_reg[i][63] ? 64'(-adj5_reg[i]) : 64'(adj5_reg[i]);
            rem_reg[i]     <= {32'b0, ua, 1'b0};
            ctl_reg[i].big <= {32'b0, ua, 1'b0} >= mag_full[96:0];
            ctl_reg[i].neg <= adj5_reg[i][63] ^ dneg;
        end
    end

    for (genvar i = 0; i < 9; i++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk  (clk),
            .mag  (mag_reg),
            .rem0 (rem_reg[i]),
            .ctl  (ctl_reg[i]),
            .res  (lane_res[i])
        );
    end

    always_comb
    begin
        if (sing_reg[SLEN-1])
        begin
            out_next           = '0;
            out_next.inv_elem0 = m3i_pkg::ONE_Q16;
            out_next.inv_elem4 = m3i_pkg::ONE_Q16;
            out_next.inv_elem8 = m3i_pkg::ONE_Q16;
            out_next.singular  = 1'b1;
        end
        else
        begin
            out_next.inv_elem0 = lane_res[0];
            out_next.inv_elem1 = lane_res[1];
            out_next.inv_elem2 = lane_res[2];
            out_next.inv_elem3 = lane_res[3];
            out_next.inv_elem4 = lane_res[4];
            out_next.inv_elem5 = lane_res[5];
            out_next.inv_elem6 = lane_res[6];
            out_next.inv_elem7 = lane_res[7];
            out_next.inv_elem8 = lane_res[8];
            out_next.singular  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

@@ design/m3i_checker.sv @@
// Port-level checks for matrix3_inverse, attached by bind.
// Depends on m3i_pkg and the top level's ports.
module m3i_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input m3i_pkg::out_t result
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(m3i_pkg::LATENCY) done)
        else $error("item lost");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, m3i_pkg::LATENCY))
        else $error("item invented");

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |->
            (result.inv_elem0 == m3i_pkg::ONE_Q16 && result.inv_elem4 == m3i_pkg::ONE_Q16
             && result.inv_elem8 == m3i_pkg::ONE_Q16 && result.inv_elem1 == 0
             && result.inv_elem3 == 0 && result.inv_elem5 == 0))
        else $error("singular result not identity");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
